### rtl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg: shared types and constants of the sample voice player
// Field widths, op codes, controller states and the controller/datapath bus.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned VOICES     = 16;
  localparam int unsigned MAX_FRAMES = 4096;

  localparam int SLOT_W   = 4;
  localparam int VOICE_W  = 4;
  localparam int FRAME_W  = 12;
  localparam int LEN_W    = 13;
  localparam int SMP_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int PITCH_W  = 24;
  localparam int POS_W    = 29;   // Q13.16
  localparam int FRAC_W   = 16;
  localparam int OUT_W    = 24;
  localparam int ACC_W    = 53;   // 16 terms of up to 2^47 plus sign
  localparam int MEM_AW   = SLOT_W + FRAME_W;
  localparam int DRAIN_CYC = 3;   // mixer stages behind the memory read

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_LOAD       = 3'd1,
    OP_UNLOAD     = 3'd2,
    OP_TRIGGER    = 3'd3,
    OP_STOP_VOICE = 3'd4,
    OP_STOP_SLOT  = 3'd5,
    OP_STOP_ALL   = 3'd6,
    OP_RENDER     = 3'd7
  } svp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DONE,
    ST_RENDER,
    ST_DRAIN,
    ST_RENDER_DONE
  } svp_state_e;

  typedef struct packed {
    logic [2:0]                op;
    logic [SLOT_W-1:0]         slot;
    logic [FRAME_W-1:0]        frame_index;
    logic signed [SMP_W-1:0]   in_left;
    logic signed [SMP_W-1:0]   in_right;
    logic [LEN_W-1:0]          length;
    logic [GAIN_W-1:0]         volume;
    logic signed [SMP_W-1:0]   pan;
    logic [PITCH_W-1:0]        pitch;
    logic [VOICE_W-1:0]        voice;
  } svp_in_t;

  typedef struct packed {
    logic                      status;
    logic [VOICE_W-1:0]        voice_sel;
    logic signed [OUT_W-1:0]   left_out;
    logic signed [OUT_W-1:0]   right_out;
  } svp_out_t;

  // controller -> datapath
  typedef struct packed {
    logic               accept;
    logic               scan;
    logic               issue;
    logic               fin_trig;
    logic               fin_render;
    logic [VOICE_W-1:0] idx;
  } svp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic immediate;   // accepted word completes in its accept cycle
  } svp_stat_t;

endpackage

### rtl/svp_if.sv
// ----------------------------------------------------------------------------
// svp_if: valid/ready channels of the sample voice player
// One interface for the command words, one for the result words.
// ----------------------------------------------------------------------------
interface svp_in_if
  import svp_pkg::*;
();
  logic    valid;
  logic    ready;
  svp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface svp_out_if
  import svp_pkg::*;
();
  logic     valid;
  logic     ready;
  svp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/svp_ctrl.sv
// ----------------------------------------------------------------------------
// svp_ctrl: sequencer of the sample voice player
// Accepts words, runs the voice steal scan and the render walk.
// ----------------------------------------------------------------------------
module svp_ctrl
  import svp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [2:0] in_op_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  svp_stat_t stat_i,
  output svp_cmd_t  cmd_o
);

  localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);
  localparam logic [VOICE_W-1:0] LAST_DRAIN = VOICE_W'(DRAIN_CYC - 1);

  svp_state_e         state_q, state_d;
  logic [VOICE_W-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          if (stat_i.immediate) begin
            out_valid_d = 1'b1;
          end else if (in_op_i == OP_RENDER) begin
            state_d = ST_RENDER;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (idx_q == LAST_VOICE) begin
          state_d = ST_SCAN_DONE;
        end
      end
      ST_SCAN_DONE: begin
        cmd_o.fin_trig = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_RENDER: begin
        cmd_o.issue = 1'b1;
        idx_d       = idx_q + 1'b1;
        if (idx_q == LAST_VOICE) begin
          idx_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_DRAIN) begin
          state_d = ST_RENDER_DONE;
        end
      end
      ST_RENDER_DONE: begin
        cmd_o.fin_render = 1'b1;
        out_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/svp_dp.sv
// ----------------------------------------------------------------------------
// svp_dp: datapath of the sample voice player
// Sample memory, slot and voice tables, steal compare, mixer pipeline.
// ----------------------------------------------------------------------------
module svp_dp
  import svp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  svp_in_t   item_i,
  input  svp_cmd_t  cmd_i,
  output svp_stat_t stat_o,
  output svp_out_t  out_o
);

  localparam int PROD_W = SMP_W + GAIN_W + 1;   // sample x gain
  localparam int TERM_W = PROD_W + FRAC_W + 2;  // x pan weight
  localparam int CMP_W  = POS_W + LEN_W;
  localparam int Q_W    = ACC_W - 31;
  localparam logic [LEN_W-1:0]   LEN_MAX = LEN_W'(MAX_FRAMES);
  localparam logic [PITCH_W-1:0] PITCH_ONE = PITCH_W'(1) << FRAC_W;
  localparam logic [ACC_W-1:0]   RND = ACC_W'(1) << 30;

  // sample memory: left in [15:0], right in [31:16]
  logic [2*SMP_W-1:0] mem [2**MEM_AW];
  logic [2*SMP_W-1:0] rd_q;
  logic [MEM_AW-1:0]  raddr;

  // slot and voice tables
  logic [LEN_W-1:0]   slot_len_q [SLOTS];
  logic [SLOTS-1:0]   slot_loaded_q;
  logic [VOICES-1:0]  playing_q;
  logic [SLOT_W-1:0]  vslot_q  [VOICES];
  logic [POS_W-1:0]   vpos_q   [VOICES];
  logic [GAIN_W-1:0]  vgain_q  [VOICES];
  logic [SMP_W-1:0]   vpan_q   [VOICES];
  logic [PITCH_W-1:0] vpitch_q [VOICES];

  svp_in_t item_q;
  svp_out_t out_q, out_d;

  // --- accept-cycle decode
  logic [VOICES-1:0]  slot_match;
  logic               trig_ok, has_idle, trig_direct;
  logic [VOICE_W-1:0] idle_idx;

  always_comb begin
    idle_idx = '0;
    for (int k = VOICES - 1; k >= 0; k--) begin
      if (!playing_q[k]) idle_idx = VOICE_W'(k);
    end
    for (int k = 0; k < VOICES; k++) begin
      slot_match[k] = playing_q[k] && (vslot_q[k] == item_i.slot);
    end
  end

  assign trig_ok     = slot_loaded_q[item_i.slot];
  assign has_idle    = !(&playing_q);
  assign trig_direct = !trig_ok || has_idle;
  assign stat_o.immediate = (item_i.op != OP_RENDER) &&
                            !((item_i.op == OP_TRIGGER) && !trig_direct);

  // --- voice claim (direct or after the steal scan)
  svp_in_t            tsrc;
  logic               commit_en;
  logic [VOICE_W-1:0] commit_idx;
  logic [VOICE_W-1:0] pick_q;

  assign tsrc       = cmd_i.accept ? item_i : item_q;
  assign commit_en  = (cmd_i.accept && item_i.op == OP_TRIGGER && trig_ok && has_idle) ||
                      cmd_i.fin_trig;
  assign commit_idx = cmd_i.accept ? idle_idx : pick_q;

  // --- current voice of the walk
  logic [SLOT_W-1:0] cur_slot;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_loaded;
  logic [POS_W-FRAC_W-1:0] cur_frame;
  logic              live, issue_stop, issue_adv;
  logic [POS_W:0]    pos_sum;
  logic [POS_W-1:0]  pos_next;

  assign cur_slot   = vslot_q[cmd_i.idx];
  assign cur_len    = slot_len_q[cur_slot];
  assign cur_loaded = slot_loaded_q[cur_slot];
  assign cur_frame  = vpos_q[cmd_i.idx][POS_W-1:FRAC_W];
  assign live       = playing_q[cmd_i.idx] && cur_loaded && (cur_frame < cur_len);
  assign issue_stop = cmd_i.issue && playing_q[cmd_i.idx] && !live;
  assign issue_adv  = cmd_i.issue && live;
  assign pos_sum    = {1'b0, vpos_q[cmd_i.idx]} + (POS_W+1)'(vpitch_q[cmd_i.idx]);
  assign pos_next   = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
  // frame < length <= MAX_FRAMES, so the low bits address the slot
  assign raddr      = {cur_slot, cur_frame[FRAME_W-1:0]};

  // --- control tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q     <= '0;
      slot_loaded_q <= '0;
      for (int k = 0; k < SLOTS; k++) slot_len_q[k] <= '0;
    end else begin
      if (cmd_i.accept) begin
        case (item_i.op)
          OP_LOAD: begin
            playing_q                    <= playing_q & ~slot_match;
            slot_len_q[item_i.slot]      <= (item_i.length > LEN_MAX) ? LEN_MAX
                                                                      : item_i.length;
            slot_loaded_q[item_i.slot]   <= 1'b1;
          end
          OP_UNLOAD: begin
            playing_q                    <= playing_q & ~slot_match;
            slot_len_q[item_i.slot]      <= '0;
            slot_loaded_q[item_i.slot]   <= 1'b0;
          end
          OP_STOP_VOICE: playing_q[item_i.voice] <= 1'b0;
          OP_STOP_SLOT:  playing_q <= playing_q & ~slot_match;
          OP_STOP_ALL:   playing_q <= '0;
          default: ;
        endcase
      end
      if (issue_stop) playing_q[cmd_i.idx] <= 1'b0;
      if (commit_en)  playing_q[commit_idx] <= 1'b1;
    end
  end

  // --- voice payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= item_i;
    if (commit_en) begin
      vslot_q[commit_idx]  <= tsrc.slot;
      vpos_q[commit_idx]   <= '0;
      vgain_q[commit_idx]  <= tsrc.volume;
      vpan_q[commit_idx]   <= tsrc.pan;
      vpitch_q[commit_idx] <= (tsrc.pitch == '0) ? PITCH_ONE : tsrc.pitch;
    end
    if (issue_adv) vpos_q[cmd_i.idx] <= pos_next;
  end

  // --- steal scan: farthest by position/length, cross-multiplied
  logic [POS_W-1:0] bp_q;
  logic [LEN_W-1:0] bl_q;
  logic             found_q;
  logic [CMP_W-1:0] lhs, rhs;
  logic             elig;

  assign lhs  = CMP_W'(vpos_q[cmd_i.idx]) * CMP_W'(bl_q);
  assign rhs  = CMP_W'(bp_q) * CMP_W'(cur_len);
  assign elig = playing_q[cmd_i.idx] && cur_loaded && (cur_len != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      pick_q  <= '0;
    end else if (cmd_i.accept) begin
      found_q <= 1'b0;
      pick_q  <= '0;   // fallback when no voice qualifies
    end else if (cmd_i.scan && elig && (!found_q || lhs > rhs)) begin
      found_q <= 1'b1;
      pick_q  <= cmd_i.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bp_q <= '0;
      bl_q <= LEN_W'(1);
    end else if (cmd_i.scan && elig && (!found_q || lhs > rhs)) begin
      bp_q <= vpos_q[cmd_i.idx];
      bl_q <= cur_len;
    end
  end

  // --- sample memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && item_i.op == OP_WRITE) begin
      mem[{item_i.slot, item_i.frame_index}] <= {item_i.in_right, item_i.in_left};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
  end

  // --- mixer pipeline: read, sample x gain, x pan weight, accumulate
  logic                     v1_q, v2_q, v3_q;
  logic [GAIN_W-1:0]        g1_q;
  logic [FRAC_W-1:0]        pr1_q, pr2_q;
  logic [FRAC_W:0]          pl1_q, pl2_q;
  logic [SMP_W-1:0]         pan_cur;
  logic signed [SMP_W-1:0]  sl, sr;
  logic signed [GAIN_W:0]   gs;
  logic signed [PROD_W-1:0] prl_q, prr_q;
  logic signed [TERM_W-1:0] tl_q, tr_q;
  logic signed [ACC_W-1:0]  accl_q, accr_q;

  assign pan_cur = vpan_q[cmd_i.idx];
  assign sl = rd_q[SMP_W-1:0];
  assign sr = rd_q[2*SMP_W-1:SMP_W];
  assign gs = {1'b0, g1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_adv;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // right weight = pan + 0.5 (offset binary), left = 1.0 - right
    g1_q  <= vgain_q[cmd_i.idx];
    pr1_q <= {~pan_cur[SMP_W-1], pan_cur[SMP_W-2:0]};
    pl1_q <= (FRAC_W+1)'(1 << FRAC_W) - {1'b0, ~pan_cur[SMP_W-1], pan_cur[SMP_W-2:0]};
    prl_q <= sl * gs;
    prr_q <= sr * gs;
    pl2_q <= pl1_q;
    pr2_q <= pr1_q;
    tl_q  <= prl_q * $signed({1'b0, pl2_q});
    tr_q  <= prr_q * $signed({2'b0, pr2_q});
    if (cmd_i.accept) begin
      accl_q <= '0;
      accr_q <= '0;
    end else if (v3_q) begin
      accl_q <= accl_q + ACC_W'(tl_q);
      accr_q <= accr_q + ACC_W'(tr_q);
    end
  end

  // round half up, divide by 2^31; the sum stays within 2^20, no clipping
  logic [ACC_W-1:0] rl, rr;
  assign rl = accl_q + RND;
  assign rr = accr_q + RND;

  always_comb begin
    out_d = '0;
    if (cmd_i.fin_render) begin
      out_d.left_out  = {{(OUT_W-Q_W){rl[ACC_W-1]}}, rl[ACC_W-1:31]};
      out_d.right_out = {{(OUT_W-Q_W){rr[ACC_W-1]}}, rr[ACC_W-1:31]};
    end else if (cmd_i.fin_trig) begin
      out_d.voice_sel = pick_q;
    end else if (item_i.op == OP_TRIGGER) begin
      out_d.status    = !trig_ok;
      out_d.voice_sel = trig_ok ? idle_idx : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.accept && stat_o.immediate) || cmd_i.fin_trig || cmd_i.fin_render) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

### rtl/sample_voice_player_unit.sv
// ----------------------------------------------------------------------------
// sample_voice_player_unit: polyphonic stereo sample player, top level
// Sixteen voices over sixteen sample slots, one result word per command word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_i     in   valid/ready    svp_in_t  (op, slot, frame, samples, trigger args)
//  out_o    out  valid/ready    svp_out_t (status, voice_sel, left_out, right_out)
//
//  Write, load, unload, stops and a trigger with an idle voice: answered from the accept decode.
//  Trigger with all voices busy: a 16-step steal scan (one compare
//  unit with two 29x13 products), then the claim.
//  Render: accept, 16-voice walk through the single sample memory read
//  port, 3 mixer stages to drain, final rounding.
//  Reset clears slot and voice state at once; the sample memory is not
//  cleared and must be written before use. A result word that is not yet
//  taken holds off the next command word.
module sample_voice_player_unit
  import svp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  svp_in_if.sink    in_i,
  svp_out_if.source out_o
);

  svp_cmd_t  cmd;
  svp_stat_t stat;

  // sequencer: accept, steal scan, render walk and drain
  svp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.data.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // tables, sample memory, mixer and result register
  svp_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_i.data),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o.data)
  );

endmodule

### rtl/svp_checker.sv
// ----------------------------------------------------------------------------
// svp_checker: port-level checks of the sample voice player
// Watches both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module svp_checker
  import svp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic [2:0] in_op_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input svp_out_t out_data_i
);

  // result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  // a new word is only taken when the result register has room
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("word accepted with result register full");

  // plain control ops answer in the next cycle
  a_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != OP_TRIGGER && in_op_i != OP_RENDER
    |=> out_valid_i)
    else $error("control op gave no result");

  // rejected trigger carries no voice and no audio
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status |->
      out_data_i.voice_sel == '0 && out_data_i.left_out == '0 &&
      out_data_i.right_out == '0)
    else $error("rejected trigger with payload");

endmodule

bind sample_voice_player_unit svp_checker u_svp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
